>>> sv/dwu_pkg.sv
// ----------------------------------------------------------------------------
// dwu_pkg
// Shared types and constants for the delta word unfilter block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwu_pkg;

    // Header progress codes: 0..3 count header bytes seen so far.
    localparam logic [2:0] HDR_DATA    = 3'd4;  // data phase
    localparam logic [2:0] HDR_OVERRUN = 3'd5;  // data phase after an overrun

    // Value of the mode register that selects 16-bit words.
    localparam logic [1:0] WB_WIDE  = 2'd2;
    localparam logic [1:0] WB_RESET = 2'd1;

    // Result queue geometry.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QIDX_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic        size_error;
        logic [23:0] declared_size;
    } dwu_res_t;

    // Results produced by one accepted input transaction (zero, one or two).
    typedef struct packed {
        logic [1:0] cnt;
        dwu_res_t   r0;
        dwu_res_t   r1;
    } dwu_push_t;

endpackage

`default_nettype wire

>>> sv/delta_word_unfilter.sv
// ----------------------------------------------------------------------------
// delta_word_unfilter
// Undoes an 8-bit or 16-bit delta filter on a byte stream with a size header.
// ----------------------------------------------------------------------------
// Usage: stream bytes enter on the in_* channel, one per transaction; the
// first four are the header (byte 0 ignored, bytes 1..3 the declared size,
// little endian) and end_of_input flags the final byte. Decoded bytes leave
// on the out_* channel, low byte of each word first, with last on the final
// result and size_error valid on that result.
// cfg_wr_en/cfg_wr_data write the word size register (2 selects 16-bit
// words, any other value 8-bit); write it only between streams.
// With an empty queue, the first result of a transaction is presented in
// the cycle after it is accepted; the second result of a 16-bit word
// leaves the queue after the first.
// Throughput: one input byte per cycle while in_stall is low. A 16-bit word releases two results
// from its second byte, so output stays at one byte per cycle on average.
// A four-entry result queue separates the two sides; in_stall rises when
// fewer than two entries are free, so a stalled receiver backs up into the
// input after at most four results.
// Reset clears the stream state and the queue and sets 8-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_word_unfilter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             size_error,
    output logic [23:0]      declared_size
);

    logic [1:0]         word_bytes_reg;
    logic               room;
    logic               accept;
    dwu_pkg::dwu_push_t push;
    dwu_pkg::dwu_res_t  head;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_bytes_reg <= dwu_pkg::WB_RESET;
        end else if (cfg_wr_en) begin
            word_bytes_reg <= cfg_wr_data;
        end
    end

    dwu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .word_bytes   (word_bytes_reg),
        .push         (push)
    );

    dwu_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (out_valid),
        .stall (out_stall),
        .head  (head)
    );

    assign out_byte      = head.out_byte;
    assign last          = head.last;
    assign size_error    = head.size_error;
    assign declared_size = head.declared_size;

endmodule

`default_nettype wire

>>> sv/dwu_decode.sv
// ----------------------------------------------------------------------------
// dwu_decode
// Header parser, size tracker and delta adder; emits up to two results per
// accepted input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              end_of_input,
    input  wire logic [1:0]        word_bytes,
    output dwu_pkg::dwu_push_t     push
);

    logic [2:0]  hdr_idx_reg,   hdr_idx_next;
    logic [23:0] decl_len_reg,  decl_len_next;
    logic [23:0] bytes_done_reg, bytes_done_next;
    logic [15:0] prev_word_reg, prev_word_next;
    logic [7:0]  held_low_reg,  held_low_next;
    logic        phase_reg,     phase_next;

    logic        wide;
    logic        half_pending;
    logic [23:0] decl_hdr;
    logic [7:0]  sum8;
    logic [15:0] sum16;
    logic        err;

    assign wide  = (word_bytes == dwu_pkg::WB_WIDE);
    assign sum8  = prev_word_reg[7:0] + in_byte;
    assign sum16 = prev_word_reg + {in_byte, held_low_reg};

    always_comb
    begin
        decl_hdr = decl_len_reg;
        case (hdr_idx_reg)
            3'd1: decl_hdr[7:0]   = decl_len_reg[7:0]   | in_byte;
            3'd2: decl_hdr[15:8]  = decl_len_reg[15:8]  | in_byte;
            3'd3: decl_hdr[23:16] = decl_len_reg[23:16] | in_byte;
            default: decl_hdr = decl_len_reg;
        endcase
    end

    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        decl_len_next   = decl_len_reg;
        bytes_done_next = bytes_done_reg;
        prev_word_next  = prev_word_reg;
        held_low_next   = held_low_reg;
        phase_next      = phase_reg;
        half_pending    = 1'b0;
        err             = 1'b0;
        push            = '0;
        push.r0.declared_size = decl_len_reg;
        push.r1.declared_size = decl_len_reg;

        if (hdr_idx_reg < dwu_pkg::HDR_DATA) begin
            decl_len_next = decl_hdr;
            hdr_idx_next  = hdr_idx_reg + 3'd1;
            if (end_of_input) begin
                // A stream ending right after a zero size header is a valid empty stream.
                push.cnt              = 2'd1;
                push.r0.out_byte      = 8'h00;
                push.r0.last          = 1'b1;
                push.r0.size_error    = !(hdr_idx_reg == 3'd3 && decl_hdr == 24'd0);
                push.r0.declared_size = decl_hdr;
            end
        end else begin
            if (bytes_done_reg < decl_len_reg) begin
                bytes_done_next = bytes_done_reg + 24'd1;
            end else begin
                hdr_idx_next = dwu_pkg::HDR_OVERRUN;
            end

            if (!wide) begin
                phase_next       = 1'b0;
                prev_word_next   = {8'h00, sum8};
                push.cnt         = 2'd1;
                push.r0.out_byte = sum8;
            end else if (!phase_reg) begin
                held_low_next = in_byte;
                phase_next    = 1'b1;
                if (end_of_input) begin
                    half_pending     = 1'b1;
                    push.cnt         = 2'd1;
                    push.r0.out_byte = sum8;
                end
            end else begin
                prev_word_next   = sum16;
                phase_next       = 1'b0;
                push.cnt         = 2'd2;
                push.r0.out_byte = sum16[7:0];
                push.r1.out_byte = sum16[15:8];
            end

            if (end_of_input) begin
                err = half_pending || (hdr_idx_next == dwu_pkg::HDR_OVERRUN)
                      || (bytes_done_next != decl_len_reg);
                if (push.cnt == 2'd2) begin
                    push.r1.last       = 1'b1;
                    push.r1.size_error = err;
                end else begin
                    push.r0.last       = 1'b1;
                    push.r0.size_error = err;
                end
            end
        end

        // The final byte of a stream returns the decoder to its idle state.
        if (end_of_input) begin
            hdr_idx_next    = '0;
            decl_len_next   = '0;
            bytes_done_next = '0;
            prev_word_next  = '0;
            held_low_next   = '0;
            phase_next      = 1'b0;
        end

        if (!accept) begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_idx_reg    <= '0;
            decl_len_reg   <= '0;
            bytes_done_reg <= '0;
            prev_word_reg  <= '0;
            held_low_reg   <= '0;
            phase_reg      <= 1'b0;
        end else if (accept) begin
            hdr_idx_reg    <= hdr_idx_next;
            decl_len_reg   <= decl_len_next;
            bytes_done_reg <= bytes_done_next;
            prev_word_reg  <= prev_word_next;
            held_low_reg   <= held_low_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/dwu_outq.sv
// ----------------------------------------------------------------------------
// dwu_outq
// Small result queue: takes up to two results per cycle, delivers one per cycle while stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module dwu_outq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dwu_pkg::dwu_push_t push,
    output logic                    room,
    output logic                    valid,
    input  wire logic               stall,
    output dwu_pkg::dwu_res_t       head
);

    dwu_pkg::dwu_res_t q_reg [dwu_pkg::QDEPTH];

    logic [dwu_pkg::QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dwu_pkg::QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dwu_pkg::QCNT_W-1:0] count_reg,  count_next;
    logic [dwu_pkg::QIDX_W-1:0] wr_ptr_p1;
    logic                       pop;

    assign valid     = (count_reg != '0);
    assign pop       = valid && !stall;
    // Space for the two results a single input transaction may produce.
    assign room      = (count_reg <= dwu_pkg::QCNT_W'(dwu_pkg::QDEPTH - 2));
    assign head      = q_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dwu_pkg::QIDX_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + dwu_pkg::QIDX_W'(pop);
        count_next  = count_reg + dwu_pkg::QCNT_W'(push.cnt)
                      - dwu_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            q_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
